### rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Register map, default sizes and pattern helper constants.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // Default sizing of the scanner.
   localparam int MAX_PATTERN_DEF = 40;
   localparam int OFFSET_BITS_DEF = 32;

   // The pattern registers always hold forty bytes.
   localparam int PATTERN_BYTES  = 40;
   localparam int PATTERN_WORDS  = 5;
   localparam int LENGTH_W       = 6;
   localparam int ADDRESS_W      = 64;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_ADDR_W     = 6;
   localparam int CSR_INDEX_W    = 3;

   // Register indexes; each register sits at byte address 8 * index.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN0 = 3'd0,
      REG_PATTERN1 = 3'd1,
      REG_PATTERN2 = 3'd2,
      REG_PATTERN3 = 3'd3,
      REG_PATTERN4 = 3'd4,
      REG_WILDCARD = 3'd5,
      REG_LENGTH   = 3'd6,
      REG_BASE     = 3'd7
   } csr_index_type;

endpackage

### rtl/core/masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Streams a region one byte per transfer and reports the address of the
// first occurrence of a configured pattern with per-byte wildcards.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   data_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready   found, match_address
//   csr      in         APB write/read        pattern, wildcards, length, base
//
// One byte is taken every cycle unless a result stalls; each byte is held in
// the input register and its result, if any, goes to the output register.
// The window of recent bytes is compared in parallel with the pattern, which
// is lined up with the window by a shift on the configured length.
// Reset clears the valid, window, count and configuration registers at once; no clearing pass is needed.
// A result waiting in the output register only stalls a byte that has a
// result of its own; bytes with no result keep flowing.
//
module masked_byte_pattern_scanner_unit
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [ADDRESS_W-1:0]  rsp_match_address,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int WIN_W = 8 * MAX_PATTERN;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0]    pattern_word_ff [PATTERN_WORDS];
   logic [PATTERN_BYTES-1:0] wildcard_ff;
   logic [LENGTH_W-1:0]      length_ff;
   logic [ADDRESS_W-1:0]     base_ff;

   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1 -: CSR_INDEX_W]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         wildcard_ff <= '0;
         length_ff   <= LENGTH_W'(1);
         base_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PATTERN0: pattern_word_ff[0] <= csr_pwdata;
            REG_PATTERN1: pattern_word_ff[1] <= csr_pwdata;
            REG_PATTERN2: pattern_word_ff[2] <= csr_pwdata;
            REG_PATTERN3: pattern_word_ff[3] <= csr_pwdata;
            REG_PATTERN4: pattern_word_ff[4] <= csr_pwdata;
            REG_WILDCARD: wildcard_ff <= csr_pwdata[PATTERN_BYTES-1:0];
            REG_LENGTH:   length_ff   <= csr_pwdata[LENGTH_W-1:0];
            REG_BASE:     base_ff     <= csr_pwdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PATTERN0: csr_prdata = pattern_word_ff[0];
         REG_PATTERN1: csr_prdata = pattern_word_ff[1];
         REG_PATTERN2: csr_prdata = pattern_word_ff[2];
         REG_PATTERN3: csr_prdata = pattern_word_ff[3];
         REG_PATTERN4: csr_prdata = pattern_word_ff[4];
         REG_WILDCARD: csr_prdata = CSR_DATA_W'(wildcard_ff);
         REG_LENGTH:   csr_prdata = CSR_DATA_W'(length_ff);
         REG_BASE:     csr_prdata = base_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // Effective length: zero counts as one, anything above the window depth
   // is clipped to it.
   logic [6:0] len_clamp;
   logic [6:0] align_shift;

   always_comb begin
      len_clamp = {1'b0, length_ff};
      if (len_clamp == 7'd0) begin
         len_clamp = 7'd1;
      end else if (len_clamp > 7'(MAX_PATTERN)) begin
         len_clamp = 7'(MAX_PATTERN);
      end
   end

   assign align_shift = 7'(MAX_PATTERN) - len_clamp;

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       in_advance;
   logic       in_has_result;
   logic       out_free;

   assign out_free   = !rsp_valid || rsp_ready;
   assign in_advance = in_valid_ff && (!in_has_result || out_free);
   assign req_ready  = !in_valid_ff || in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // ------------------------------------------------------------------
   // Byte window, most recent byte in the low byte. The pattern is held
   // reversed and shifted down by the unused positions, so that pattern
   // byte 0 lines up with the oldest byte of a candidate match.
   // ------------------------------------------------------------------
   logic [WIN_W-1:0]       window_ff;
   logic [WIN_W-1:0]       window_in;
   logic [WIN_W-1:0]       pattern_rev;
   logic [WIN_W-1:0]       pattern_aligned;
   logic [MAX_PATTERN-1:0] wild_rev;
   logic [MAX_PATTERN-1:0] wild_aligned;
   logic [MAX_PATTERN-1:0] in_use;
   logic [MAX_PATTERN-1:0] byte_match;
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic [OFFSET_BITS-1:0] match_offset;
   logic                   done_ff;
   logic                   hit;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
      localparam int P = MAX_PATTERN - 1 - k;
      if (P < PATTERN_BYTES) begin : g_cfg
         assign pattern_rev[8*k +: 8] = pattern_word_ff[P / 8][8 * (P % 8) +: 8];
         assign wild_rev[k]           = wildcard_ff[P];
      end else begin : g_zero
         // Positions beyond the pattern registers hold a plain zero byte.
         assign pattern_rev[8*k +: 8] = 8'd0;
         assign wild_rev[k]           = 1'b0;
      end
      assign byte_match[k] = !in_use[k] || wild_aligned[k] ||
         (window_in[8*k +: 8] == pattern_aligned[8*k +: 8]);
   end

   assign window_in       = WIN_W'({window_ff, in_byte_ff});
   assign pattern_aligned = pattern_rev >> {align_shift, 3'b000};
   assign wild_aligned    = wild_rev >> align_shift;
   assign in_use          = {MAX_PATTERN{1'b1}} >> align_shift;

   assign count_in      = (count_ff == {OFFSET_BITS{1'b1}}) ? count_ff
                                                             : count_ff + 1'b1;
   assign hit           = (&byte_match) && (count_in >= OFFSET_BITS'(len_clamp));
   assign match_offset  = count_in - OFFSET_BITS'(len_clamp);
   assign in_has_result = !done_ff && (hit || in_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else if (in_advance) begin
         if (in_last_ff) begin
            window_ff <= '0;
            count_ff  <= '0;
            done_ff   <= 1'b0;
         end else if (!done_ff) begin
            window_ff <= window_in;
            count_ff  <= count_in;
            done_ff   <= hit;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic                 out_valid_ff;
   logic                 out_found_ff;
   logic [ADDRESS_W-1:0] out_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_advance && in_has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && in_has_result) begin
         out_found_ff   <= hit;
         out_address_ff <= hit ? base_ff + ADDRESS_W'(match_offset) : '0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_match_address = out_address_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_not_found_zero_address: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_address_ff == '0))
      else $error("not-found result carries a non-zero address");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      (in_advance && in_last_ff) |=> (window_ff == '0 && count_ff == '0 && !done_ff))
      else $error("scan state not cleared after the last byte of a region");

   a_match_sets_done: assert property (@(posedge clock) disable iff (reset)
      (in_advance && !done_ff && hit && !in_last_ff) |=> done_ff)
      else $error("match reported but rest of region not suppressed");

   a_done_no_result: assert property (@(posedge clock) disable iff (reset)
      (in_advance && done_ff) |=> !(out_valid_ff && !$past(out_valid_ff)))
      else $error("result produced after the region already matched");

endmodule
